// File: rtl/core/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debouncer with long-press
// detection: item codes, press machine states and per-button control.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Number of buttons, which sets the pin and flag field widths
  localparam int unsigned BUTTONS = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned MODE_W  = 2;

  // Configuration registers
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TICKS_W    = 16;

  // Default counter width and register reset values
  localparam int unsigned TIMER_BITS_DEF  = 16;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd300;
  localparam logic PRESSED_LEVEL_RESET = 1'b0;

  // History depth and reset contents (released level = high after reset)
  localparam int unsigned HIST_W = 3;
  localparam logic [HIST_W-1:0] HIST_RESET  = '1;
  localparam logic              LEVEL_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS_TICKS = 1'b0,
    CFG_PRESSED_LEVEL    = 1'b1
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 2'd0,
    MODE_CLR_PRESS = 2'd1,
    MODE_CLR_LONG  = 2'd2,
    MODE_RELEASED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_LONG     = 2'd2
  } press_state_e;

  // Per-button control for one processed item
  typedef struct packed {
    logic tick;
    logic sample;
    logic clr_press;
    logic clr_long;
  } btn_ctrl_t;

  // Per-button status: current flags/level and values after this item
  typedef struct packed {
    logic level_now;
    logic press_now;
    logic long_now;
    logic level_next;
    logic press_next;
    logic long_next;
  } btn_stat_t;

endpackage

// File: rtl/core/bdlp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_in_if / bdlp_out_if
// Valid/ready channels carrying debouncer items and results.
// ----------------------------------------------------------------------------
interface bdlp_in_if;
  import bdlp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [BUTTONS-1:0]     raw_pins;
  logic [IDX_W-1:0]       button_index;

  modport source (output valid, output mode, output raw_pins, output button_index,
                  input ready);
  modport sink   (input valid, input mode, input raw_pins, input button_index,
                  output ready);
endinterface

interface bdlp_out_if;
  import bdlp_pkg::*;

  logic               valid;
  logic               ready;
  logic               answer;
  logic [BUTTONS-1:0] press_flags;
  logic [BUTTONS-1:0] long_flags;
  logic [BUTTONS-1:0] debounced_levels;

  modport source (output valid, output answer, output press_flags, output long_flags,
                  output debounced_levels, input ready);
  modport sink   (input valid, input answer, input press_flags, input long_flags,
                  input debounced_levels, output ready);
endinterface

// File: rtl/core/bdlp_button.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_button
// One button: three-sample debounce, released/pressed/long-pressed machine,
// hold countdown and sticky press and long-press flags.
// ----------------------------------------------------------------------------
module bdlp_button import bdlp_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btn_ctrl_t             ctrl_i,
  input  logic                  pressed_level_i,
  input  logic [TIMER_BITS-1:0] load_i,
  output btn_stat_t             stat_o
);

  logic [HIST_W-1:0]     hist_q, hist_d;
  logic                  level_q, level_d;
  logic                  press_q, press_d;
  logic                  long_q, long_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d;
  press_state_e          state_q, state_d;
  logic                  held;

  // Shift the sample in and update the debounced level on agreement
  always_comb begin
    hist_d  = hist_q;
    level_d = level_q;
    if (ctrl_i.tick) begin
      hist_d = {hist_q[HIST_W-2:0], ctrl_i.sample};
      if ((hist_d == '0) || (hist_d == '1)) begin
        level_d = ctrl_i.sample;
      end
    end
  end

  assign held = (level_d == pressed_level_i);

  // Press machine, countdown and flags
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    press_d = press_q;
    long_d  = long_q;
    if (ctrl_i.clr_press) begin
      press_d = 1'b0;
    end
    if (ctrl_i.clr_long) begin
      long_d = 1'b0;
    end
    if (ctrl_i.tick) begin
      unique case (state_q)
        ST_PRESSED: begin
          if (cnt_q <= TIMER_BITS'(1)) begin
            cnt_d   = '0;
            long_d  = 1'b1;
            state_d = ST_LONG;
          end else begin
            cnt_d = cnt_q - TIMER_BITS'(1);
          end
          if (!held) begin
            cnt_d   = '0;
            state_d = ST_RELEASED;
          end
        end
        ST_LONG: begin
          if (!held) begin
            state_d = ST_RELEASED;
          end
        end
        default: begin
          if (held) begin
            press_d = 1'b1;
            cnt_d   = load_i;
            state_d = ST_PRESSED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= HIST_RESET;
      level_q <= LEVEL_RESET;
      press_q <= 1'b0;
      long_q  <= 1'b0;
      cnt_q   <= '0;
      state_q <= ST_RELEASED;
    end else begin
      hist_q  <= hist_d;
      level_q <= level_d;
      press_q <= press_d;
      long_q  <= long_d;
      cnt_q   <= cnt_d;
      state_q <= state_d;
    end
  end

  assign stat_o.level_now  = level_q;
  assign stat_o.press_now  = press_q;
  assign stat_o.long_now   = long_q;
  assign stat_o.level_next = level_d;
  assign stat_o.press_next = press_d;
  assign stat_o.long_next  = long_d;

endmodule

// File: rtl/core/button_debounce_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces raw button samples and reports press and long-press events.
// Path: the input register holds the accepted item; the button update and
//   result are then registered into the result register when it is free.
// Throughput: one item per cycle unless the result stalls; all buttons in parallel.
// Reset: asynchronous; all buttons released, flags clear, registers at
//   defaults (300 ticks, active-low buttons).
// ----------------------------------------------------------------------------
module button_debounce_long_press import bdlp_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bdlp_in_if.sink               in_i,
  bdlp_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [32:0] CntMax = (33'd1 << TIMER_BITS) - 33'd1;

  logic [TICKS_W-1:0]    ticks_q;
  logic                  plevel_q;
  logic [TIMER_BITS-1:0] load;

  logic                  s1_valid_q;
  logic [MODE_W-1:0]     s1_mode_q;
  logic [BUTTONS-1:0]    s1_pins_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  advance;
  logic                  idx_ok;
  mode_e                 mode;

  btn_ctrl_t             ctrl [BUTTONS];
  btn_stat_t             stat [BUTTONS];

  logic                  answer_d, answer_q;
  logic [BUTTONS-1:0]    press_d, press_q;
  logic [BUTTONS-1:0]    long_d, long_q;
  logic [BUTTONS-1:0]    level_d, level_q;
  logic                  out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q  <= TICKS_RESET;
      plevel_q <= PRESSED_LEVEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LONG_PRESS_TICKS: ticks_q  <= cfg_wdata_i[TICKS_W-1:0];
        CFG_PRESSED_LEVEL:    plevel_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Saturate the hold time to the countdown width
  assign load = ((33'(ticks_q)) > CntMax) ? CntMax[TIMER_BITS-1:0]
                                          : TIMER_BITS'(33'(ticks_q));

  // Advance the input stage when the result register is free
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Hold the item payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_mode_q <= in_i.mode;
      s1_pins_q <= in_i.raw_pins;
      s1_idx_q  <= in_i.button_index;
    end
  end

  assign mode   = mode_e'(s1_mode_q);
  assign idx_ok = (32'(s1_idx_q) < BUTTONS);

  // Per-button control
  always_comb begin
    for (int i = 0; i < BUTTONS; i++) begin
      ctrl[i].tick      = advance && (mode == MODE_TICK);
      ctrl[i].sample    = s1_pins_q[i];
      ctrl[i].clr_press = advance && (mode == MODE_CLR_PRESS) && idx_ok &&
                          (s1_idx_q == IDX_W'(i));
      ctrl[i].clr_long  = advance && (mode == MODE_CLR_LONG) && idx_ok &&
                          (s1_idx_q == IDX_W'(i));
    end
  end

  for (genvar g = 0; g < BUTTONS; g++) begin : g_btn
    bdlp_button #(
      .TIMER_BITS (TIMER_BITS)
    ) u_btn (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl[g]),
      .pressed_level_i (plevel_q),
      .load_i          (load),
      .stat_o          (stat[g])
    );
  end

  // Form the answer and the flag vectors after this item
  always_comb begin
    answer_d = 1'b0;
    for (int i = 0; i < BUTTONS; i++) begin
      press_d[i] = stat[i].press_next;
      long_d[i]  = stat[i].long_next;
      level_d[i] = stat[i].level_next;
      if (idx_ok && (s1_idx_q == IDX_W'(i))) begin
        case (mode)
          MODE_CLR_PRESS: answer_d = stat[i].press_now;
          MODE_CLR_LONG:  answer_d = stat[i].long_now;
          MODE_RELEASED:  answer_d = (stat[i].level_now != plevel_q);
          default:        answer_d = 1'b0;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      answer_q <= answer_d;
      press_q  <= press_d;
      long_q   <= long_d;
      level_q  <= level_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.answer           = answer_q;
  assign out_o.press_flags      = press_q;
  assign out_o.long_flags       = long_q;
  assign out_o.debounced_levels = level_q;

endmodule

// File: rtl/core/bdlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of the debouncer's flow control and result timing.
// ----------------------------------------------------------------------------
module bdlp_checker import bdlp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BUTTONS-1:0] out_press,
  input logic [BUTTONS-1:0] out_long
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result flags hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_press) && $stable(out_long))
    else $error("result flags changed while stalled");

  // Input back-pressure only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // An accepted item loads the result register at the next edge when the
  // output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("result missing after accepted item");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_press (out_o.press_flags),
  .out_long  (out_o.long_flags)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - button debouncer with long-press detection
// Drives tick and query items through the valid/ready input channel and
// compares every result against an in-bench debounce and press-machine
// model. A directed table at reset settings comes first, then random phases
// over several hold times and both pressed levels, with idling on both sides
// and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import bdlp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF       = 300;
  localparam int unsigned PHASE_ITEMS    = 175;
  localparam int unsigned N_PHASES       = 6;
  localparam int unsigned DIR_N          = 25;
  localparam int unsigned PRINT_CAP      = 40;

  typedef struct packed {
    logic               answer;
    logic [BUTTONS-1:0] press_flags;
    logic [BUTTONS-1:0] long_flags;
    logic [BUTTONS-1:0] levels;
  } btn_report_t;

  typedef struct packed {
    mode_e              mode;
    logic [BUTTONS-1:0] pins;
    logic [IDX_W-1:0]   idx;
    logic               typed;
    btn_report_t        fixed;
  } dir_row_t;

  // Directed items; typed rows hold results known straight from reset
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{MODE_RELEASED,  3'd0, 3'd0, 1'b1, '{1'b1, 3'd0, 3'd0, 3'd7}},
    '{MODE_CLR_PRESS, 3'd0, 3'd2, 1'b1, '{1'b0, 3'd0, 3'd0, 3'd7}},
    '{MODE_CLR_LONG,  3'd0, 3'd1, 1'b1, '{1'b0, 3'd0, 3'd0, 3'd7}},
    '{MODE_RELEASED,  3'd0, 3'd7, 1'b1, '{1'b0, 3'd0, 3'd0, 3'd7}},
    '{MODE_CLR_PRESS, 3'd0, 3'd3, 1'b1, '{1'b0, 3'd0, 3'd0, 3'd7}},
    '{MODE_TICK,      3'd7, 3'd0, 1'b1, '{1'b0, 3'd0, 3'd0, 3'd7}},
    '{MODE_TICK,      3'd0, 3'd0, 1'b0, '0},
    '{MODE_TICK,      3'd0, 3'd0, 1'b0, '0},
    '{MODE_TICK,      3'd0, 3'd0, 1'b0, '0},
    '{MODE_CLR_PRESS, 3'd7, 3'd0, 1'b0, '0},
    '{MODE_CLR_PRESS, 3'd0, 3'd0, 1'b0, '0},
    '{MODE_RELEASED,  3'd0, 3'd1, 1'b0, '0},
    '{MODE_TICK,      3'd5, 3'd0, 1'b0, '0},
    '{MODE_TICK,      3'd2, 3'd0, 1'b0, '0},
    '{MODE_TICK,      3'd7, 3'd0, 1'b0, '0},
    '{MODE_TICK,      3'd7, 3'd0, 1'b0, '0},
    '{MODE_TICK,      3'd7, 3'd0, 1'b0, '0},
    '{MODE_RELEASED,  3'd0, 3'd2, 1'b0, '0},
    '{MODE_CLR_PRESS, 3'd0, 3'd1, 1'b0, '0},
    '{MODE_CLR_PRESS, 3'd0, 3'd2, 1'b0, '0},
    '{MODE_CLR_LONG,  3'd0, 3'd0, 1'b0, '0},
    '{MODE_CLR_LONG,  3'd0, 3'd4, 1'b0, '0},
    '{MODE_CLR_PRESS, 3'd0, 3'd5, 1'b0, '0},
    '{MODE_RELEASED,  3'd0, 3'd6, 1'b0, '0},
    '{MODE_TICK,      3'd6, 3'd7, 1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bdlp_in_if  in_ch ();
  bdlp_out_if out_ch ();

  button_debounce_long_press u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // Model state and configuration
  logic [2:0]         smp_hist  [BUTTONS];
  logic               deb_level [BUTTONS];
  press_state_e       btn_state [BUTTONS];
  logic [TICKS_W-1:0] hold_cnt  [BUTTONS];
  logic               press_pend[BUTTONS];
  logic               long_pend [BUTTONS];
  logic [TICKS_W-1:0] hold_ticks;
  logic               level_cfg;

  btn_report_t pending_reports[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_requests;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at result %0d: %0s got %0h want %0h", results_seen, what, got, want);
    end
  endtask

  // Advance the model by one item and return the result it produces
  function automatic btn_report_t debounce_step(mode_e m, logic [BUTTONS-1:0] pins,
                                                logic [IDX_W-1:0] idx);
    btn_report_t r;
    logic        held;
    r = '0;
    if (m == MODE_TICK) begin
      for (int i = 0; i < BUTTONS; i++) begin
        smp_hist[i] = {smp_hist[i][1:0], pins[i]};
        if (smp_hist[i] == 3'b000 || smp_hist[i] == 3'b111) deb_level[i] = pins[i];
        held = (deb_level[i] == level_cfg);
        case (btn_state[i])
          ST_PRESSED: begin
            if (hold_cnt[i] <= 1) begin
              hold_cnt[i]  = '0;
              long_pend[i] = 1'b1;
              btn_state[i] = ST_LONG;
            end else begin
              hold_cnt[i] = hold_cnt[i] - 1'b1;
            end
            if (!held) begin
              hold_cnt[i]  = '0;
              btn_state[i] = ST_RELEASED;
            end
          end
          ST_LONG: begin
            if (!held) btn_state[i] = ST_RELEASED;
          end
          default: begin
            if (held) begin
              press_pend[i] = 1'b1;
              hold_cnt[i]   = hold_ticks;
              btn_state[i]  = ST_PRESSED;
            end
          end
        endcase
      end
    end else if (idx < BUTTONS) begin
      case (m)
        MODE_CLR_PRESS: begin
          r.answer        = press_pend[idx];
          press_pend[idx] = 1'b0;
        end
        MODE_CLR_LONG: begin
          r.answer       = long_pend[idx];
          long_pend[idx] = 1'b0;
        end
        default: r.answer = (deb_level[idx] != level_cfg);
      endcase
    end
    for (int i = 0; i < BUTTONS; i++) begin
      r.press_flags[i] = press_pend[i];
      r.long_flags[i]  = long_pend[i];
      r.levels[i]      = deb_level[i];
    end
    return r;
  endfunction

  // Offer one item, wait for its handshake, then queue its expected result
  task automatic offer_item(mode_e m, logic [BUTTONS-1:0] pins, logic [IDX_W-1:0] idx,
                            logic typed, btn_report_t fixed);
    int unsigned gap;
    btn_report_t want;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(3, 1);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.raw_pins     <= pins;
    in_ch.button_index <= idx;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    want = debounce_step(m, pins, idx);
    if (typed) want = fixed;
    pending_reports.push_back(want);
  endtask

  task automatic stop_offer();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e r, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= data;
    @(posedge clk_i);
    if (r == CFG_LONG_PRESS_TICKS) hold_ticks = data;
    else level_cfg = data[0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : rx_driver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    btn_report_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.answer !== want.answer)
          report_mismatch("answer", out_ch.answer, want.answer);
        if (out_ch.press_flags !== want.press_flags)
          report_mismatch("press_flags", out_ch.press_flags, want.press_flags);
        if (out_ch.long_flags !== want.long_flags)
          report_mismatch("long_flags", out_ch.long_flags, want.long_flags);
        if (out_ch.debounced_levels !== want.levels)
          report_mismatch("debounced_levels", out_ch.debounced_levels, want.levels);
      end
    end
  end

  // End the run if neither channel moves an item for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus
  initial begin : stim
    logic [TICKS_W-1:0]  phase_ticks [N_PHASES];
    logic                phase_level [N_PHASES];
    logic [BUTTONS-1:0]  target;
    logic [BUTTONS-1:0]  noise;
    int unsigned         pick;
    mode_e               m;
    logic [IDX_W-1:0]    idx;

    phase_ticks = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd20, 16'd2};
    phase_level = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TICK;
    in_ch.raw_pins     = '0;
    in_ch.button_index = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_LONG_PRESS_TICKS;
    cfg_wdata          = '0;
    mismatches         = 0;
    results_seen       = 0;
    hold_requests      = 0;
    tx_idle_pct        = 37;
    rx_idle_pct        = 71;

    // Model reset: active-low buttons, all released
    hold_ticks = 16'd300;
    level_cfg  = 1'b0;
    for (int i = 0; i < BUTTONS; i++) begin
      smp_hist[i]   = 3'b111;
      deb_level[i]  = 1'b1;
      btn_state[i]  = ST_RELEASED;
      hold_cnt[i]   = '0;
      press_pend[i] = 1'b0;
      long_pend[i]  = 1'b0;
    end

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table at reset settings
    for (int k = 0; k < DIR_N; k++) begin
      offer_item(DIR_ROWS[k].mode, DIR_ROWS[k].pins, DIR_ROWS[k].idx, DIR_ROWS[k].typed,
                 DIR_ROWS[k].fixed);
    end

    // Random phases: held targets with bounce noise, queries in between
    for (int p = 0; p < N_PHASES; p++) begin
      stop_offer();
      wait_drained();
      write_reg(CFG_LONG_PRESS_TICKS, phase_ticks[p]);
      write_reg(CFG_PRESSED_LEVEL, {15'($urandom), phase_level[p]});
      case (p / 2)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      target = 3'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 1 || p == 4) && n == 60) hold_requests++;
        pick = $urandom_range(99);
        if (pick < 8) begin
          offer_item(mode_e'($urandom_range(3)), 3'($urandom), 3'($urandom), 1'b0, '0);
        end else if (pick < 68) begin
          for (int i = 0; i < BUTTONS; i++) begin
            if ($urandom_range(23) == 0) target[i] = ~target[i];
            noise[i] = ($urandom_range(99) < 8);
          end
          offer_item(MODE_TICK, target ^ noise, 3'($urandom), 1'b0, '0);
        end else begin
          m   = mode_e'($urandom_range(3, 1));
          idx = ($urandom_range(99) < 15) ? 3'($urandom) : 3'($urandom_range(BUTTONS - 1));
          offer_item(m, 3'($urandom), idx, 1'b0, '0);
        end
      end
    end

    // Drain and settle
    stop_offer();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_reports.size() != 0) report_mismatch("results missing", 0, 1);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
